@@ design/pag_pkg.sv @@
`timescale 1ns / 1ps

package pag_pkg;

   localparam int LINEAR_BITS  = 16;
   localparam int COLOR_BITS   = 8;
   localparam int NUM_LANES    = 3;
   localparam int ROM_DEPTH    = 1 << COLOR_BITS;
   localparam int PROD_BITS    = LINEAR_BITS + COLOR_BITS;
   localparam int SEARCH_STEPS = COLOR_BITS;
   localparam int LANE_STAGES  = 2 + SEARCH_STEPS;
   localparam int PIPE_STAGES  = LANE_STAGES + 1;
   localparam int TDATA_BITS   = (NUM_LANES + 1) * COLOR_BITS;
   localparam int BIG_BITS     = 256;

   // exact floor(x / 255) for any 32-bit x: (x * DIV_MUL) >> DIV_SHIFT
   localparam int                   DIV_BITS   = 32;
   localparam logic [DIV_BITS-1:0]  DIV_MUL    = 32'h8080_8081;
   localparam int                   DIV_SHIFT  = 39;
   localparam logic [COLOR_BITS-1:0] ROUND_BIAS = 8'd127;

   localparam logic [LINEAR_BITS-1:0] FULL_SCALE = '1;

   typedef logic [LINEAR_BITS-1:0] lin_type;
   typedef lin_type                lin_rom_type [ROM_DEPTH];
   typedef logic [BIG_BITS-1:0]    big_type;

   typedef struct packed {
      logic [PIPE_STAGES-1:0] adv;
   } pipe_ctrl_type;

   function automatic big_type big_pow(big_type base, int unsigned e);
      big_type r;
      r = big_type'(1);
      for (int unsigned i = 0; i < e; i++) begin
         r = r * base;
      end
      return r;
   endfunction

   // largest v with (2v-1)^5 * 255^11 <= 32 * FS^5 * c^11
   function automatic lin_rom_type build_dec_rom();
      lin_rom_type  rom;
      big_type      rhs;
      big_type      lhs;
      logic [31:0]  lo;
      logic [31:0]  hi;
      logic [31:0]  mid;
      for (int c = 0; c < ROM_DEPTH; c++) begin
         rhs = big_type'(32) * big_pow(big_type'(FULL_SCALE), 5)
               * big_pow(big_type'(c), 11);
         lo  = '0;
         hi  = 32'(FULL_SCALE);
         while (lo < hi) begin
            mid = lo + ((hi - lo + 32'd1) >> 1);
            lhs = big_pow(big_type'(2 * mid - 32'd1), 5)
                  * big_pow(big_type'(ROM_DEPTH - 1), 11);
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 32'd1;
            end
         end
         rom[c] = lo[LINEAR_BITS-1:0];
      end
      return rom;
   endfunction

   // smallest t with t^5 * 510^11 >= FS^5 * (2k-1)^11, zero for k = 0
   function automatic lin_rom_type build_thr_rom();
      lin_rom_type  rom;
      big_type      rhs;
      big_type      lhs;
      logic [31:0]  lo;
      logic [31:0]  hi;
      logic [31:0]  mid;
      rom[0] = '0;
      for (int k = 1; k < ROM_DEPTH; k++) begin
         rhs = big_pow(big_type'(FULL_SCALE), 5) * big_pow(big_type'(2 * k - 1), 11);
         lo  = '0;
         hi  = 32'(FULL_SCALE);
         while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            lhs = big_pow(big_type'(mid), 5)
                  * big_pow(big_type'(2 * (ROM_DEPTH - 1)), 11);
            if (lhs >= rhs) begin
               hi = mid;
            end else begin
               lo = mid + 32'd1;
            end
         end
         rom[k] = lo[LINEAR_BITS-1:0];
      end
      return rom;
   endfunction

   localparam lin_rom_type DEC_ROM = build_dec_rom();
   localparam lin_rom_type THR_ROM = build_thr_rom();

endpackage

@@ design/premultiply_alpha_gamma.sv @@
`timescale 1ns / 1ps

// Premultiplies an 8-bit RGBA pixel by its alpha in linear light using a pure
// 2.2 power law. One pixel is accepted per clock while the output is not
// stalled; results stream out in order through one stage for decode ROM and
// alpha multiply, one for the reciprocal divide by 255, eight for the
// bit-by-bit threshold search that re-encodes the color, and the output
// register. Red, green and blue run in three identical lanes; alpha passes
// through unchanged. Back-pressure stalls only the stages that are full, so
// bubbles are squeezed out. No registers to program and no start-up pass.

module premultiply_alpha_gamma (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pag_pkg::TDATA_BITS-1:0]  req_tdata,  // red_in, green_in, blue_in, alpha_in
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pag_pkg::TDATA_BITS-1:0]  rsp_tdata   // red_out, green_out, blue_out, alpha_out
);
   import pag_pkg::*;

   pipe_ctrl_type          pipe_ctrl;
   logic [COLOR_BITS-1:0]  alpha_ff [LANE_STAGES];
   logic [COLOR_BITS-1:0]  lane_out [NUM_LANES];
   logic [TDATA_BITS-1:0]  rsp_tdata_ff;
   logic [TDATA_BITS-1:0]  rsp_tdata_in;
   logic [COLOR_BITS-1:0]  alpha_req;

   assign alpha_req = req_tdata[NUM_LANES*COLOR_BITS +: COLOR_BITS];

   pag_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .pipe_ctrl  (pipe_ctrl)
   );

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      pag_lane u_lane (
         .clock     (clock),
         .pipe_ctrl (pipe_ctrl),
         .color_in  (req_tdata[l*COLOR_BITS +: COLOR_BITS]),
         .alpha_in  (alpha_req),
         .color_out (lane_out[l])
      );
   end

   for (genvar s = 0; s < LANE_STAGES; s++) begin : g_alpha
      always_ff @(posedge clock) begin
         if (pipe_ctrl.adv[s]) begin
            alpha_ff[s] <= (s == 0) ? alpha_req : alpha_ff[(s == 0) ? 0 : s - 1];
         end
      end
   end

   // merge lane results and alpha into the output register
   always_comb begin
      rsp_tdata_in = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
         rsp_tdata_in[l*COLOR_BITS +: COLOR_BITS] = lane_out[l];
      end
      rsp_tdata_in[NUM_LANES*COLOR_BITS +: COLOR_BITS] = alpha_ff[LANE_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (pipe_ctrl.adv[PIPE_STAGES-1]) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;

   a_zero_alpha : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[NUM_LANES*COLOR_BITS +: COLOR_BITS] == '0)
      |-> (rsp_tdata[NUM_LANES*COLOR_BITS-1:0] == '0))
      else $error("color not zero for zero alpha");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule

@@ design/pag_ctrl.sv @@
`timescale 1ns / 1ps

module pag_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output pag_pkg::pipe_ctrl_type pipe_ctrl
);
   import pag_pkg::*;

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] adv;

   // a stage takes new contents when empty or when its contents move on
   always_comb begin
      adv[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_tready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[0] = adv[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign pipe_ctrl.adv = adv;
   assign req_tready    = adv[0];
   assign rsp_tvalid    = valid_ff[PIPE_STAGES-1];

endmodule

@@ design/pag_lane.sv @@
`timescale 1ns / 1ps

module pag_lane (
   input  logic                             clock,
   input  pag_pkg::pipe_ctrl_type           pipe_ctrl,
   input  logic [pag_pkg::COLOR_BITS-1:0]   color_in,
   input  logic [pag_pkg::COLOR_BITS-1:0]   alpha_in,
   output logic [pag_pkg::COLOR_BITS-1:0]   color_out
);
   import pag_pkg::*;

   logic [PROD_BITS-1:0]    prod_ff;
   logic [PROD_BITS-1:0]    prod_in;
   lin_type                 quot_ff;
   lin_type                 quot_in;
   logic [DIV_BITS-1:0]     biased;
   logic [2*DIV_BITS-1:0]   recip;
   logic [COLOR_BITS-1:0]   k_ff [SEARCH_STEPS];
   logic [COLOR_BITS-1:0]   k_in [SEARCH_STEPS];
   lin_type                 p_ff [SEARCH_STEPS-1];
   lin_type                 p_in [SEARCH_STEPS-1];

   // decode to linear light and scale by alpha
   assign prod_in = PROD_BITS'(DEC_ROM[color_in]) * PROD_BITS'(alpha_in);

   always_ff @(posedge clock) begin
      if (pipe_ctrl.adv[0]) begin
         prod_ff <= prod_in;
      end
   end

   // divide by 255 with rounding through a reciprocal multiply
   assign biased  = DIV_BITS'(prod_ff) + DIV_BITS'(ROUND_BIAS);
   assign recip   = (2*DIV_BITS)'(biased) * (2*DIV_BITS)'(DIV_MUL);
   assign quot_in = recip[DIV_SHIFT +: LINEAR_BITS];

   always_ff @(posedge clock) begin
      if (pipe_ctrl.adv[1]) begin
         quot_ff <= quot_in;
      end
   end

   // re-encode: binary search over the threshold table, one bit a stage
   for (genvar j = 0; j < SEARCH_STEPS; j++) begin : g_step
      logic [COLOR_BITS-1:0] k_prev;
      logic [COLOR_BITS-1:0] cand;
      lin_type               p_prev;

      if (j == 0) begin : g_first
         assign k_prev = '0;
         assign p_prev = quot_ff;
      end else begin : g_next
         assign k_prev = k_ff[j-1];
         assign p_prev = p_ff[j-1];
      end

      assign cand    = k_prev | (COLOR_BITS'(1) << (COLOR_BITS - 1 - j));
      assign k_in[j] = (THR_ROM[cand] <= p_prev) ? cand : k_prev;

      always_ff @(posedge clock) begin
         if (pipe_ctrl.adv[2+j]) begin
            k_ff[j] <= k_in[j];
         end
      end

      if (j < SEARCH_STEPS - 1) begin : g_keep
         assign p_in[j] = p_prev;
         always_ff @(posedge clock) begin
            if (pipe_ctrl.adv[2+j]) begin
               p_ff[j] <= p_in[j];
            end
         end
      end
   end

   assign color_out = k_ff[SEARCH_STEPS-1];

endmodule
